// ----- hw/rtl/thruster_mixer_pwm_assert.svh -----
// Assertion macros used by the thruster mixer back end (tmix_back).
`ifndef THRUSTER_MIXER_PWM_ASSERT_SVH
`define THRUSTER_MIXER_PWM_ASSERT_SVH

// Checks prop at every rising clock edge outside reset.
`define TMIX_ASSERT(lbl, prop, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (prop)) else $error(msg);

// Checks that cond is never true outside reset.
`define TMIX_ASSERT_NEVER(lbl, cond, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) !(cond)) else $error(msg);

`endif

// ----- hw/rtl/tmix_pkg.sv -----
package tmix_pkg;

  localparam int unsigned AXIS_W      = 8;
  localparam int unsigned VAL_W       = 10;
  localparam int unsigned PULSE_W     = 16;
  localparam int unsigned CENTER_W    = 12;
  localparam int unsigned GAIN_W      = 4;
  localparam int unsigned CFG_IDX_W   = 2;
  localparam int unsigned CFG_DATA_W  = 12;
  localparam int unsigned NUM_H       = 4;
  localparam int unsigned NUM_V       = 3;
  localparam int unsigned NUM_OUT     = NUM_H + NUM_V;
  localparam int unsigned QUEUE_DEPTH = 2;

  localparam logic [CENTER_W-1:0] CENTER_RESET = 12'd1500;
  localparam logic [GAIN_W-1:0]   GAIN_RESET   = 4'd5;

  // Magnitude thresholds where the integer divisor H/100 reaches 2 and 3.
  localparam logic [VAL_W-2:0] DIV2_FLOOR = 9'd200;
  localparam logic [VAL_W-2:0] DIV3_FLOOR = 9'd300;

  // Reciprocal of three, exact for magnitudes below 512.
  localparam logic [7:0] RECIP3       = 8'd171;
  localparam int unsigned RECIP3_SHIFT = 9;

  // One bit per thruster and axis: set where the axis enters negated.
  // Axis order is surge, sway, yaw.
  localparam logic [NUM_H-1:0][2:0] MIX_NEG = '{
    3'b001, // thruster four: -surge, +sway, +yaw
    3'b100, // thruster three: +surge, +sway, -yaw
    3'b111, // thruster two: -surge, -sway, -yaw
    3'b010  // thruster one: +surge, -sway, +yaw
  };

  typedef enum logic [CFG_IDX_W-1:0] {
    CFG_CENTER = 2'd0,
    CFG_GAIN   = 2'd1
  } cfg_idx_e;

  typedef enum logic [1:0] {
    DIV_BY1 = 2'd0,
    DIV_BY2 = 2'd1,
    DIV_BY3 = 2'd2
  } div_e;

  typedef logic signed [VAL_W-1:0] val_t;

  typedef struct packed {
    val_t [NUM_H-1:0] h;
    val_t [NUM_V-1:0] v;
    div_e             div;
  } item_t;

  typedef struct packed {
    logic [CENTER_W-1:0] center;
    logic [GAIN_W-1:0]   gain;
  } cfg_t;

endpackage

// ----- hw/rtl/tmix_front.sv -----
module tmix_front (
  input  logic signed [tmix_pkg::AXIS_W-1:0] surge_cmd_i,
  input  logic signed [tmix_pkg::AXIS_W-1:0] sway_cmd_i,
  input  logic signed [tmix_pkg::AXIS_W-1:0] yaw_cmd_i,
  input  logic signed [tmix_pkg::AXIS_W-1:0] heave_cmd_i,
  output tmix_pkg::item_t                   item_o
);
  import tmix_pkg::*;

  val_t [2:0]           axis;
  val_t [NUM_H-1:0]     sum;
  logic [VAL_W-2:0]     mag [NUM_H];
  logic [VAL_W-2:0]     max01;
  logic [VAL_W-2:0]     max23;
  logic [VAL_W-2:0]     highest;
  val_t                 heave_neg;
  val_t                 heave_adj;

  assign axis[0] = VAL_W'(surge_cmd_i);
  assign axis[1] = VAL_W'(sway_cmd_i);
  assign axis[2] = VAL_W'(yaw_cmd_i);

  always_comb begin
    for (int i = 0; i < NUM_H; i++) begin
      sum[i] = '0;
      for (int k = 0; k < 3; k++) begin
        if (MIX_NEG[i][k]) begin
          sum[i] = sum[i] - axis[k];
        end else begin
          sum[i] = sum[i] + axis[k];
        end
      end
      mag[i] = sum[i][VAL_W-1] ? (VAL_W-1)'(-sum[i]) : sum[i][VAL_W-2:0];
    end
  end

  assign max01   = (mag[0] > mag[1]) ? mag[0] : mag[1];
  assign max23   = (mag[2] > mag[3]) ? mag[2] : mag[3];
  assign highest = (max01 > max23) ? max01 : max23;

  // Halving truncates toward zero, so negative values are biased by one first.
  assign heave_neg = -VAL_W'(heave_cmd_i);
  assign heave_adj = heave_neg + VAL_W'(heave_neg[VAL_W-1]);

  always_comb begin
    item_o.h = sum;
    item_o.v[0] = {heave_adj[VAL_W-1], heave_adj[VAL_W-1:1]};
    item_o.v[1] = {heave_adj[VAL_W-1], heave_adj[VAL_W-1:1]};
    item_o.v[2] = heave_neg;
    if (highest >= DIV3_FLOOR) begin
      item_o.div = DIV_BY3;
    end else if (highest >= DIV2_FLOOR) begin
      item_o.div = DIV_BY2;
    end else begin
      item_o.div = DIV_BY1;
    end
  end

endmodule

// ----- hw/rtl/tmix_queue.sv -----
module tmix_queue #(
  parameter int unsigned Depth = tmix_pkg::QUEUE_DEPTH
) (
  input  logic            clk_i,
  input  logic            rst_ni,
  input  logic            push_i,
  input  tmix_pkg::item_t item_i,
  output logic            full_o,
  output logic            valid_o,
  output tmix_pkg::item_t item_o
);
  import tmix_pkg::*;

  localparam int unsigned PtrW = (Depth > 1) ? $clog2(Depth) : 1;
  localparam int unsigned CntW = $clog2(Depth + 1);

  item_t            mem_q [Depth];
  logic [PtrW-1:0]  wr_ptr_q, wr_ptr_d;
  logic [PtrW-1:0]  rd_ptr_q, rd_ptr_d;
  logic [CntW-1:0]  count_q, count_d;
  logic             pop;

  assign full_o  = (count_q == CntW'(Depth));
  assign valid_o = (count_q != '0);
  assign item_o  = mem_q[rd_ptr_q];
  // The back end never stalls, so whatever is queued leaves right away.
  assign pop     = valid_o;

  always_comb begin
    wr_ptr_d = wr_ptr_q;
    rd_ptr_d = rd_ptr_q;
    count_d  = count_q;
    if (push_i) begin
      wr_ptr_d = (wr_ptr_q == PtrW'(Depth - 1)) ? '0 : wr_ptr_q + 1'b1;
    end
    if (pop) begin
      rd_ptr_d = (rd_ptr_q == PtrW'(Depth - 1)) ? '0 : rd_ptr_q + 1'b1;
    end
    if (push_i && !pop) begin
      count_d = count_q + 1'b1;
    end else if (pop && !push_i) begin
      count_d = count_q - 1'b1;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
      count_q  <= '0;
    end else begin
      wr_ptr_q <= wr_ptr_d;
      rd_ptr_q <= rd_ptr_d;
      count_q  <= count_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (push_i) begin
      mem_q[wr_ptr_q] <= item_i;
    end
  end

endmodule

// ----- hw/rtl/tmix_back.sv -----
module tmix_back (
  input  logic                                    clk_i,
  input  logic                                    rst_ni,
  input  logic                                    valid_i,
  input  tmix_pkg::item_t                         item_i,
  input  tmix_pkg::cfg_t                          cfg_i,
  output logic                                    done_o,
  output logic [tmix_pkg::NUM_OUT-1:0][tmix_pkg::PULSE_W-1:0] pulse_o
);
  import tmix_pkg::*;

  `include "thruster_mixer_pwm_assert.svh"

  localparam int unsigned MagW  = VAL_W - 1;
  localparam int unsigned ProdW = MagW + 8;

  logic                                 val_valid_q;
  val_t [NUM_OUT-1:0]                   val_q, val_d;
  logic                                 done_q;
  logic [NUM_OUT-1:0][PULSE_W-1:0]      pulse_q, pulse_d;

  logic [MagW-1:0]  mag  [NUM_H];
  logic [MagW-1:0]  quot [NUM_H];
  logic [ProdW-1:0] prod [NUM_H];

  // First stage: divide each horizontal sum by 1, 2 or 3 on its magnitude; pass the vertical values through.
  always_comb begin
    for (int i = 0; i < NUM_H; i++) begin
      mag[i]  = item_i.h[i][VAL_W-1] ? MagW'(-item_i.h[i]) : item_i.h[i][MagW-1:0];
      prod[i] = ProdW'(mag[i]) * ProdW'(RECIP3);
      case (item_i.div)
        DIV_BY1: quot[i] = mag[i];
        DIV_BY2: quot[i] = mag[i] >> 1;
        DIV_BY3: quot[i] = MagW'(prod[i] >> RECIP3_SHIFT);
        default: quot[i] = mag[i];
      endcase
      val_d[i] = item_i.h[i][VAL_W-1] ? -VAL_W'(quot[i]) : VAL_W'(quot[i]);
    end
    for (int j = 0; j < NUM_V; j++) begin
      val_d[NUM_H + j] = item_i.v[j];
    end
  end

  // Second stage: scale and offset; the low 16 bits of the two's complement
  // product equal those of the unsigned one.
  always_comb begin
    logic [PULSE_W-1:0]   ext;
    logic [2*PULSE_W-1:0] scaled;
    for (int i = 0; i < NUM_OUT; i++) begin
      ext        = {{(PULSE_W - VAL_W){val_q[i][VAL_W-1]}}, val_q[i]};
      scaled     = (2*PULSE_W)'(ext) * (2*PULSE_W)'(cfg_i.gain);
      pulse_d[i] = scaled[PULSE_W-1:0] + PULSE_W'(cfg_i.center);
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      val_valid_q <= 1'b0;
      done_q      <= 1'b0;
    end else begin
      val_valid_q <= valid_i;
      done_q      <= val_valid_q;
    end
  end

  always_ff @(posedge clk_i) begin
    val_q   <= val_d;
    pulse_q <= pulse_d;
  end

  assign done_o  = done_q;
  assign pulse_o = pulse_q;

  `TMIX_ASSERT(queued_item_taken, valid_i |=> val_valid_q, "queued item not taken by back end")
  `TMIX_ASSERT(scaled_item_out, val_valid_q |=> done_o, "divided item did not reach the output")
  `TMIX_ASSERT(done_has_source, done_o |-> $past(val_valid_q), "result strobe without a source item")

endmodule

// ----- hw/rtl/thruster_mixer_pwm.sv -----
// Channel   Handshake                       Payload
// command   start_i / busy_o                surge_cmd_i, sway_cmd_i, yaw_cmd_i, heave_cmd_i
// result    done_o (one-cycle strobe)       pulse_h1_o..pulse_h4_o, pulse_v1_o..pulse_v3_o
// config    cfg_valid_i / cfg_ready_o       cfg_index_i, cfg_data_i
//
// A frame is taken at any edge with start_i high and busy_o low, one per cycle.
// Its result is strobed on done_o once it has passed the pipeline: the divider works on the
// queue head and its result is registered, then the gain multiplier works on that value and
// the pulse widths are registered together with done_o, where the receiver takes the word.
// The receiver cannot stall, so the queue drains every cycle and busy_o stays low.
// Reset clears the queue and pipeline valids and loads center 1500 and gain 5.
module thruster_mixer_pwm #(
  parameter int unsigned QueueDepth = tmix_pkg::QUEUE_DEPTH
) (
  input  logic                                clk_i,
  input  logic                                rst_ni,
  input  logic                                start_i,
  output logic                                busy_o,
  input  logic signed [tmix_pkg::AXIS_W-1:0]  surge_cmd_i,
  input  logic signed [tmix_pkg::AXIS_W-1:0]  sway_cmd_i,
  input  logic signed [tmix_pkg::AXIS_W-1:0]  yaw_cmd_i,
  input  logic signed [tmix_pkg::AXIS_W-1:0]  heave_cmd_i,
  input  logic                                cfg_valid_i,
  output logic                                cfg_ready_o,
  input  logic [tmix_pkg::CFG_IDX_W-1:0]      cfg_index_i,
  input  logic [tmix_pkg::CFG_DATA_W-1:0]     cfg_data_i,
  output logic                                done_o,
  output logic [tmix_pkg::PULSE_W-1:0]        pulse_h1_o,
  output logic [tmix_pkg::PULSE_W-1:0]        pulse_h2_o,
  output logic [tmix_pkg::PULSE_W-1:0]        pulse_h3_o,
  output logic [tmix_pkg::PULSE_W-1:0]        pulse_h4_o,
  output logic [tmix_pkg::PULSE_W-1:0]        pulse_v1_o,
  output logic [tmix_pkg::PULSE_W-1:0]        pulse_v2_o,
  output logic [tmix_pkg::PULSE_W-1:0]        pulse_v3_o
);
  import tmix_pkg::*;

  item_t                            front_item;
  item_t                            queue_item;
  logic                             queue_valid;
  logic                             queue_full;
  logic                             accept;
  cfg_t                             cfg_q, cfg_d;
  logic [NUM_OUT-1:0][PULSE_W-1:0]  pulse;

  assign accept      = start_i && !queue_full;
  assign busy_o      = queue_full;
  assign cfg_ready_o = 1'b1;

  always_comb begin
    cfg_d = cfg_q;
    if (cfg_valid_i) begin
      if (cfg_index_i == CFG_CENTER) begin
        cfg_d.center = cfg_data_i[CENTER_W-1:0];
      end else if (cfg_index_i == CFG_GAIN) begin
        cfg_d.gain = cfg_data_i[GAIN_W-1:0];
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q.center <= CENTER_RESET;
      cfg_q.gain   <= GAIN_RESET;
    end else begin
      cfg_q <= cfg_d;
    end
  end

  tmix_front u_front (
    .surge_cmd_i (surge_cmd_i),
    .sway_cmd_i  (sway_cmd_i),
    .yaw_cmd_i   (yaw_cmd_i),
    .heave_cmd_i (heave_cmd_i),
    .item_o      (front_item)
  );

  tmix_queue #(
    .Depth (QueueDepth)
  ) u_queue (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .push_i  (accept),
    .item_i  (front_item),
    .full_o  (queue_full),
    .valid_o (queue_valid),
    .item_o  (queue_item)
  );

  tmix_back u_back (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .valid_i (queue_valid),
    .item_i  (queue_item),
    .cfg_i   (cfg_q),
    .done_o  (done_o),
    .pulse_o (pulse)
  );

  assign pulse_h1_o = pulse[0];
  assign pulse_h2_o = pulse[1];
  assign pulse_h3_o = pulse[2];
  assign pulse_h4_o = pulse[3];
  assign pulse_v1_o = pulse[4];
  assign pulse_v2_o = pulse[5];
  assign pulse_v3_o = pulse[6];

endmodule

// ----- dv/thruster_mixer_pwm_test.sv -----
module thruster_mixer_pwm_test;
  timeunit 1ns;
  timeprecision 1ps;

  import tmix_pkg::*;

  localparam int unsigned LATENCY        = 3;
  localparam int unsigned WATCHDOG_LIMIT = 2000;
  localparam int unsigned RANDOM_PHASES  = 8;
  localparam int unsigned PHASE_FRAMES   = 100;
  localparam int unsigned REPORT_LIMIT   = 10;

  // Register indexes that the block does not decode.
  localparam logic [CFG_IDX_W-1:0] CFG_SPARE_LO = 2'd2;
  localparam logic [CFG_IDX_W-1:0] CFG_SPARE_HI = 2'd3;

  // Bit k of row i is set where axis k (surge, sway, yaw) enters thruster i+1 negated.
  localparam logic [NUM_H-1:0][2:0] THRUST_NEG = {3'b001, 3'b100, 3'b111, 3'b010};

  typedef logic [NUM_OUT-1:0][PULSE_W-1:0] pulse_set_t;

  logic                       clk_i = 1'b0;
  logic                       rst_ni;
  logic                       start_i;
  logic                       busy_o;
  logic signed [AXIS_W-1:0]   surge_cmd_i;
  logic signed [AXIS_W-1:0]   sway_cmd_i;
  logic signed [AXIS_W-1:0]   yaw_cmd_i;
  logic signed [AXIS_W-1:0]   heave_cmd_i;
  logic                       cfg_valid_i;
  logic                       cfg_ready_o;
  logic [CFG_IDX_W-1:0]       cfg_index_i;
  logic [CFG_DATA_W-1:0]      cfg_data_i;
  logic                       done_o;
  logic [PULSE_W-1:0]         pulse_h1_o;
  logic [PULSE_W-1:0]         pulse_h2_o;
  logic [PULSE_W-1:0]         pulse_h3_o;
  logic [PULSE_W-1:0]         pulse_h4_o;
  logic [PULSE_W-1:0]         pulse_v1_o;
  logic [PULSE_W-1:0]         pulse_v2_o;
  logic [PULSE_W-1:0]         pulse_v3_o;

  pulse_set_t          expected_pulses[$];
  logic [CENTER_W-1:0] center_shadow;
  logic [GAIN_W-1:0]   gain_shadow;
  int unsigned         mismatch_count;
  int unsigned         stall_cycles;
  int unsigned         quiet_left;
  string               pulse_names[NUM_OUT] = '{"pulse_h1", "pulse_h2", "pulse_h3",
                                                "pulse_h4", "pulse_v1", "pulse_v2",
                                                "pulse_v3"};

  thruster_mixer_pwm u_dut (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .start_i     (start_i),
    .busy_o      (busy_o),
    .surge_cmd_i (surge_cmd_i),
    .sway_cmd_i  (sway_cmd_i),
    .yaw_cmd_i   (yaw_cmd_i),
    .heave_cmd_i (heave_cmd_i),
    .cfg_valid_i (cfg_valid_i),
    .cfg_ready_o (cfg_ready_o),
    .cfg_index_i (cfg_index_i),
    .cfg_data_i  (cfg_data_i),
    .done_o      (done_o),
    .pulse_h1_o  (pulse_h1_o),
    .pulse_h2_o  (pulse_h2_o),
    .pulse_h3_o  (pulse_h3_o),
    .pulse_h4_o  (pulse_h4_o),
    .pulse_v1_o  (pulse_v1_o),
    .pulse_v2_o  (pulse_v2_o),
    .pulse_v3_o  (pulse_v3_o)
  );

  always #5 clk_i = ~clk_i;

  // The pulse width wraps to 16 bits; it is never clamped.
  function automatic logic [PULSE_W-1:0] pulse_width(input int value,
                                                     input logic [CENTER_W-1:0] center,
                                                     input logic [GAIN_W-1:0] gain);
    int raw;
    raw = value * int'(gain) + int'(center);
    return raw[PULSE_W-1:0];
  endfunction

  function automatic pulse_set_t mix_frame(input logic signed [AXIS_W-1:0] surge,
                                           input logic signed [AXIS_W-1:0] sway,
                                           input logic signed [AXIS_W-1:0] yaw,
                                           input logic signed [AXIS_W-1:0] heave,
                                           input logic [CENTER_W-1:0] center,
                                           input logic [GAIN_W-1:0] gain);
    int         axis[3];
    int         sums[NUM_H];
    int         highest;
    int         divisor;
    int         lift;
    pulse_set_t widths;
    axis[0] = surge;
    axis[1] = sway;
    axis[2] = yaw;
    lift = heave;
    highest = 0;
    for (int i = 0; i < NUM_H; i++) begin
      sums[i] = 0;
      for (int k = 0; k < 3; k++) begin
        sums[i] += THRUST_NEG[i][k] ? -axis[k] : axis[k];
      end
      if ((sums[i] < 0 ? -sums[i] : sums[i]) > highest) begin
        highest = sums[i] < 0 ? -sums[i] : sums[i];
      end
    end
    divisor = (highest > 100) ? highest / 100 : 1;
    for (int i = 0; i < NUM_H; i++) begin
      widths[i] = pulse_width(sums[i] / divisor, center, gain);
    end
    // SystemVerilog integer division truncates toward zero, as the halving requires.
    widths[NUM_H]     = pulse_width((-lift) / 2, center, gain);
    widths[NUM_H + 1] = pulse_width((-lift) / 2, center, gain);
    widths[NUM_H + 2] = pulse_width(-lift, center, gain);
    return widths;
  endfunction

  function automatic void flag_mismatch(input string what);
    mismatch_count++;
    if (mismatch_count <= REPORT_LIMIT) begin
      $display("mismatch at %0t: %s", $realtime, what);
    end
  endfunction

  // Mostly short gaps, a few long ones, and runs where frames go back to back.
  function automatic int unsigned pick_gap();
    int unsigned roll;
    if (quiet_left > 0) begin
      quiet_left--;
      return 0;
    end
    roll = $urandom_range(0, 99);
    if (roll < 4) begin
      quiet_left = $urandom_range(10, 60);
      return 0;
    end else if (roll < 50) begin
      return 0;
    end else if (roll < 85) begin
      return $urandom_range(1, 3);
    end else if (roll < 97) begin
      return $urandom_range(4, 10);
    end
    return $urandom_range(20, 60);
  endfunction

  // Called at a falling edge; returns at a falling edge with start_i still high.
  task automatic send_frame(input logic signed [AXIS_W-1:0] surge,
                            input logic signed [AXIS_W-1:0] sway,
                            input logic signed [AXIS_W-1:0] yaw,
                            input logic signed [AXIS_W-1:0] heave);
    int unsigned gap;
    gap = pick_gap();
    if (gap > 0) begin
      start_i <= 1'b0;
      repeat (gap) @(negedge clk_i);
    end
    start_i     <= 1'b1;
    surge_cmd_i <= surge;
    sway_cmd_i  <= sway;
    yaw_cmd_i   <= yaw;
    heave_cmd_i <= heave;
    do @(posedge clk_i); while (busy_o);
    expected_pulses.push_back(mix_frame(surge, sway, yaw, heave, center_shadow, gain_shadow));
    @(negedge clk_i);
  endtask

  task automatic drain_pipeline();
    start_i <= 1'b0;
    while (expected_pulses.size() != 0) @(negedge clk_i);
    repeat (LATENCY + 2) @(negedge clk_i);
  endtask

  // Returns at a falling edge with cfg_valid_i still high; the caller drops it.
  task automatic write_reg(input logic [CFG_IDX_W-1:0] index,
                           input logic [CFG_DATA_W-1:0] data);
    cfg_valid_i <= 1'b1;
    cfg_index_i <= index;
    cfg_data_i  <= data;
    do @(posedge clk_i); while (!cfg_ready_o);
    if (index == CFG_CENTER) begin
      center_shadow = data[CENTER_W-1:0];
    end else if (index == CFG_GAIN) begin
      gain_shadow = data[GAIN_W-1:0];
    end
    @(negedge clk_i);
  endtask

  task automatic set_scale(input logic [CENTER_W-1:0] center,
                           input logic [CFG_DATA_W-1:0] gain_word);
    drain_pipeline();
    write_reg(CFG_CENTER, center);
    write_reg(CFG_GAIN, gain_word);
    cfg_valid_i <= 1'b0;
  endtask

  function automatic logic signed [AXIS_W-1:0] random_axis();
    if ($urandom_range(0, 4) == 0) begin
      return AXIS_W'($urandom_range(0, 255));
    end
    return AXIS_W'($urandom_range(0, 200) - 100);
  endfunction

  // Reset settings, with sums placed on both sides of each divisor step.
  task automatic test_directed_frames();
    send_frame(8'sd0, 8'sd0, 8'sd0, 8'sd0);
    send_frame(8'sd100, 8'sd0, 8'sd0, 8'sd100);
    send_frame(-8'sd100, 8'sd0, 8'sd0, -8'sd100);
    send_frame(8'sd100, -8'sd100, 8'sd100, 8'sd1);
    send_frame(-8'sd100, -8'sd100, -8'sd100, -8'sd1);
    send_frame(8'sd51, -8'sd50, 8'sd0, 8'sd3);
    send_frame(8'sd100, -8'sd99, 8'sd0, 8'sd0);
    send_frame(8'sd100, -8'sd100, 8'sd0, -8'sd3);
    send_frame(8'sd100, -8'sd100, 8'sd99, 8'sd0);
    send_frame(-8'sd100, 8'sd100, -8'sd1, 8'sd0);
    send_frame(8'sd7, -8'sd100, 8'sd100, 8'sd5);
    send_frame(-8'sd128, -8'sd128, -8'sd128, -8'sd128);
    send_frame(8'sd127, 8'sd127, 8'sd127, 8'sd127);
    send_frame(8'sd127, -8'sd128, 8'sd127, 8'sd0);
    send_frame(8'sd0, 8'sd0, 8'sd0, -8'sd127);
  endtask

  // Extreme settings, masking of the gain word, and writes to undecoded indexes.
  task automatic test_register_writes();
    set_scale(12'd0, 12'hFFF);
    send_frame(8'sd100, -8'sd100, 8'sd100, 8'sd100);
    send_frame(-8'sd128, 8'sd127, -8'sd1, 8'sd127);
    drain_pipeline();
    write_reg(CFG_SPARE_LO, CFG_DATA_W'($urandom));
    write_reg(CFG_SPARE_HI, CFG_DATA_W'($urandom));
    cfg_valid_i <= 1'b0;
    send_frame(8'sd50, 8'sd25, -8'sd75, -8'sd128);
    set_scale(12'd4095, 12'hFF0);
    send_frame(8'sd127, 8'sd127, 8'sd127, 8'sd127);
    send_frame(-8'sd128, -8'sd128, -8'sd128, -8'sd128);
    set_scale(12'd4095, 12'd15);
    send_frame(8'sd127, -8'sd128, 8'sd127, -8'sd128);
    send_frame(-8'sd100, 8'sd100, -8'sd100, 8'sd100);
  endtask

  task automatic test_random_frames();
    logic [CENTER_W-1:0]   center;
    logic [CFG_DATA_W-1:0] gain_word;
    for (int phase = 0; phase < RANDOM_PHASES; phase++) begin
      gain_word = CFG_DATA_W'($urandom);
      case (phase)
        0: begin
          center = '0;
          gain_word[GAIN_W-1:0] = '0;
        end
        1: begin
          center = '1;
          gain_word[GAIN_W-1:0] = '1;
        end
        2: begin
          center = CENTER_RESET;
          gain_word[GAIN_W-1:0] = GAIN_RESET;
        end
        default: begin
          center = CENTER_W'($urandom);
        end
      endcase
      set_scale(center, gain_word);
      for (int n = 0; n < PHASE_FRAMES; n++) begin
        send_frame(random_axis(), random_axis(), random_axis(), random_axis());
      end
    end
  endtask

  // Each strobed word is matched against the oldest prediction.
  always @(posedge clk_i) begin
    pulse_set_t seen;
    pulse_set_t want;
    seen = {pulse_v3_o, pulse_v2_o, pulse_v1_o, pulse_h4_o, pulse_h3_o, pulse_h2_o,
            pulse_h1_o};
    if (rst_ni && done_o) begin
      if (expected_pulses.size() == 0) begin
        flag_mismatch("result word with no frame outstanding");
      end else begin
        want = expected_pulses.pop_front();
        for (int i = 0; i < NUM_OUT; i++) begin
          if (seen[i] !== want[i]) begin
            flag_mismatch($sformatf("%s expected %0d, got %0d", pulse_names[i], want[i],
                                    seen[i]));
          end
        end
      end
    end
  end

  always @(posedge clk_i) begin
    if (rst_ni) begin
      if ((start_i && !busy_o) || done_o || (cfg_valid_i && cfg_ready_o)) begin
        stall_cycles <= 0;
      end else if (stall_cycles + 1 >= WATCHDOG_LIMIT) begin
        $display("status: fail");
        $finish;
      end else begin
        stall_cycles <= stall_cycles + 1;
      end
    end
  end

  initial begin
    rst_ni         = 1'b0;
    start_i        = 1'b0;
    surge_cmd_i    = '0;
    sway_cmd_i     = '0;
    yaw_cmd_i      = '0;
    heave_cmd_i    = '0;
    cfg_valid_i    = 1'b0;
    cfg_index_i    = '0;
    cfg_data_i     = '0;
    center_shadow  = CENTER_RESET;
    gain_shadow    = GAIN_RESET;
    mismatch_count = 0;
    stall_cycles   = 0;
    quiet_left     = 0;
    repeat (9) @(negedge clk_i);
    rst_ni <= 1'b1;
    @(negedge clk_i);
    test_directed_frames();
    test_register_writes();
    test_random_frames();
    drain_pipeline();
    if (mismatch_count == 0 && expected_pulses.size() == 0) begin
      $display("status: pass");
    end else begin
      $display("status: fail");
    end
    $finish;
  end

endmodule

// ----- thruster_mixer_pwm.f -----
+incdir+hw/rtl
hw/rtl/tmix_pkg.sv
hw/rtl/tmix_front.sv
hw/rtl/tmix_queue.sv
hw/rtl/tmix_back.sv
hw/rtl/thruster_mixer_pwm.sv
dv/thruster_mixer_pwm_test.sv
